[hw/rtl/wav_riff_header_parser_macros.svh]
// Assertion macros shared by the RIFF/WAVE header parser RTL.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef WAV_RIFF_HEADER_PARSER_MACROS_SVH
`define WAV_RIFF_HEADER_PARSER_MACROS_SVH

// Clocked property, switched off while reset is held.
`define WRP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define WRP_ASSERT_NEVER(label, expr, msg) \
    `WRP_ASSERT(label, !(expr), msg)

`endif

[hw/rtl/wrp_pkg.sv]
// Types and constants for the RIFF/WAVE header parser.
// No dependencies; imported by every module of the block.
package wrp_pkg;

    localparam logic [31:0] TAG_RIFF      = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE      = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT       = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA      = 32'h6461_7461;
    localparam logic [31:0] CHUNK_HDR_LEN = 32'd8;
    localparam logic [31:0] FMT_LEN       = 32'd16;
    localparam logic [15:0] FMT_PCM       = 16'd1;

    typedef enum logic [2:0] {
        ST_OK,
        ST_NOT_RIFF,
        ST_FMT_SMALL,
        ST_DATA_FIRST,
        ST_MISSING,
        ST_NOT_PCM
    } t_status;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       first_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [15:0] sample_bits;
        logic [31:0] data_bytes;
        logic [31:0] data_start;
        logic [31:0] sample_total;
    } t_out_item;

    // Work done on the byte of the current transaction
    typedef enum logic [2:0] {
        OP_NONE,
        OP_RIFF,
        OP_CHDR,
        OP_FMT,
        OP_SKIP
    } t_byte_op;

    // Next value of the field countdown
    typedef enum logic [2:0] {
        CD_KEEP,
        CD_DEC,
        CD_FLAG,
        CD_HDR,
        CD_FMT,
        CD_SIZE,
        CD_EXTRA
    } t_cd_sel;

    typedef struct packed {
        logic     clr;
        t_byte_op op;
        t_cd_sel  cd_sel;
        logic     load_extra;
        logic     set_fmt;
        logic     res_load;
        t_status  res_status;
        logic     div_start;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic pos3;
        logic pos11;
        logic riff_bad;
        logic wave_ok;
        logic flag;
        logic cd_last;
        logic is_fmt;
        logic is_data;
        logic fmt_small;
        logic size_zero;
        logic extra_zero;
        logic fmt_seen;
        logic pcm;
        logic bpb_zero;
        logic div_done;
    } t_dp_status;

endpackage

[hw/rtl/wav_riff_header_parser.sv]
// RIFF/WAVE header parser, top level: controller, datapath, output register.
// Depends on wrp_pkg, wrp_ctrl and wrp_dpath.
//
// Input channel: one file byte per transaction (i_in_item), with marks for
// the first and last byte of a file. A first mark restarts the parse.
// Output channel: one result per file (o_out_item): status, fmt fields,
// data chunk size and offset, and the sample count.
// Throughput: one byte per cycle while parsing. The byte that ends the
// parse stalls the input until its result sits in the output register.
// For a good header with a nonzero bytes-per-sample value the stall also
// covers the 32-step shift-subtract divider that forms the sample count.
// Bytes after a result and before the next first mark are taken and dropped.
// The output register holds a result while i_out_stall is high; parsing of
// further bytes goes on meanwhile, and a second result waits in the
// datapath with the input stalled until the register frees.
// Reset (synchronous, active low) puts the block idle, waiting for a first
// mark, with the output register empty.

module wav_riff_header_parser
    import wrp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    t_out_item  w_result;
    logic       w_out_free;
    logic       r_out_valid;
    t_out_item  r_out;

    assign w_out_free = !r_out_valid || !i_out_stall;

    wrp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_first    (i_in_item.first_byte),
        .i_last     (i_in_item.last_byte),
        .i_out_free (w_out_free),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    wrp_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_file_byte (i_in_item.file_byte),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.out_load) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

[hw/rtl/wrp_ctrl.sv]
// Parse controller of the RIFF/WAVE header parser: phase state machine.
// Depends on wrp_pkg and wav_riff_header_parser_macros.svh.
`include "wav_riff_header_parser_macros.svh"

module wrp_ctrl
    import wrp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_first,
    input  logic       i_last,
    input  logic       i_out_free,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_in_stall
);

    typedef enum logic [2:0] {
        S_DONE,
        S_RIFF,
        S_CHDR,
        S_FMT,
        S_SKIP,
        S_DIV,
        S_HOLD
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_state  w_phase;
    t_dp_cmd w_cmd;
    logic    w_take;
    logic    w_res;
    t_status w_code;

    always_comb begin
        w_cmd      = '0;
        n_state    = r_state;
        w_phase    = r_state;
        w_res      = 1'b0;
        w_code     = ST_OK;
        o_in_stall = (r_state == S_DIV) || (r_state == S_HOLD);
        w_take     = i_in_valid && !o_in_stall;
        case (r_state)
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (i_out_free) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_DONE;
                end
            end
            default: begin
                if (w_take) begin
                    w_cmd.clr = i_first;
                    w_phase   = i_first ? S_RIFF : r_state;
                    case (w_phase)
                        S_RIFF: begin
                            w_cmd.op = OP_RIFF;
                            n_state  = S_RIFF;
                            if (i_status.pos3 && i_status.riff_bad) begin
                                w_cmd.cd_sel = CD_FLAG;
                            end
                            if (i_status.pos11) begin
                                if (i_status.flag || !i_status.wave_ok) begin
                                    w_res  = 1'b1;
                                    w_code = ST_NOT_RIFF;
                                end else begin
                                    n_state      = S_CHDR;
                                    w_cmd.cd_sel = CD_HDR;
                                end
                            end
                        end
                        S_CHDR: begin
                            w_cmd.op     = OP_CHDR;
                            w_cmd.cd_sel = CD_DEC;
                            if (i_status.cd_last) begin
                                if (i_status.is_fmt) begin
                                    if (i_status.fmt_small) begin
                                        w_res  = 1'b1;
                                        w_code = ST_FMT_SMALL;
                                    end else begin
                                        n_state          = S_FMT;
                                        w_cmd.cd_sel     = CD_FMT;
                                        w_cmd.load_extra = 1'b1;
                                    end
                                end else if (i_status.is_data) begin
                                    w_res = 1'b1;
                                    if (!i_status.fmt_seen) begin
                                        w_code = ST_DATA_FIRST;
                                    end else if (!i_status.pcm) begin
                                        w_code = ST_NOT_PCM;
                                    end else begin
                                        w_code = ST_OK;
                                    end
                                end else if (i_status.size_zero) begin
                                    w_cmd.cd_sel = CD_HDR;
                                end else begin
                                    n_state      = S_SKIP;
                                    w_cmd.cd_sel = CD_SIZE;
                                end
                            end
                        end
                        S_FMT: begin
                            w_cmd.op     = OP_FMT;
                            w_cmd.cd_sel = CD_DEC;
                            if (i_status.cd_last) begin
                                w_cmd.set_fmt = 1'b1;
                                if (i_status.extra_zero) begin
                                    n_state      = S_CHDR;
                                    w_cmd.cd_sel = CD_HDR;
                                end else begin
                                    n_state      = S_SKIP;
                                    w_cmd.cd_sel = CD_EXTRA;
                                end
                            end
                        end
                        S_SKIP: begin
                            w_cmd.op     = OP_SKIP;
                            w_cmd.cd_sel = CD_DEC;
                            if (i_status.cd_last) begin
                                n_state      = S_CHDR;
                                w_cmd.cd_sel = CD_HDR;
                            end
                        end
                        default: begin
                            // idle: drop the byte
                        end
                    endcase
                    // early end of input
                    if (w_phase != S_DONE && !w_res && i_last) begin
                        w_res  = 1'b1;
                        w_code = (n_state == S_RIFF) ? ST_NOT_RIFF : ST_MISSING;
                    end
                    if (w_res) begin
                        w_cmd.res_load   = 1'b1;
                        w_cmd.res_status = w_code;
                        if (w_code == ST_OK && !i_status.bpb_zero) begin
                            w_cmd.div_start = 1'b1;
                            n_state         = S_DIV;
                        end else begin
                            n_state = S_HOLD;
                        end
                    end
                end
            end
        endcase
    end

    assign o_cmd = w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_DONE;
        end else begin
            r_state <= n_state;
        end
    end

    `WRP_ASSERT(a_res_leaves_parse, w_cmd.res_load |=> (r_state == S_DIV || r_state == S_HOLD), "result did not stop the parse")
    `WRP_ASSERT(a_load_to_idle, w_cmd.out_load |=> (r_state == S_DONE), "output load did not return to idle")
    `WRP_ASSERT_NEVER(a_done_outside_div, i_status.div_done && (r_state != S_DIV), "divide finished outside the divide state")

endmodule

[hw/rtl/wrp_dpath.sv]
// Datapath of the RIFF/WAVE header parser: byte counters, header shift,
// fmt capture, result staging and a radix-2 sample-count divider.
// Depends on wrp_pkg and wav_riff_header_parser_macros.svh.
`include "wav_riff_header_parser_macros.svh"

module wrp_dpath
    import wrp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_file_byte,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output t_out_item  o_result
);

    localparam int DIV_STEPS = 32;
    localparam int DEN_W     = 13;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    logic [31:0] r_pos, n_pos, e_pos;
    logic [31:0] r_cd, n_cd, e_cd;
    logic [63:0] r_shift, n_shift, e_shift;
    logic        r_fmt_seen, n_fmt_seen, e_fmt_seen;
    logic [15:0] r_fmt_code, n_fmt_code, e_fmt_code;
    logic [15:0] r_chan, n_chan, e_chan;
    logic [31:0] r_rate, n_rate, e_rate;
    logic [15:0] r_bits, n_bits, e_bits;
    t_out_item   r_res;

    logic [31:0]      r_div_quo;
    logic [DEN_W-1:0] r_div_rem;
    logic [DEN_W-1:0] r_div_den;
    logic [CNT_W-1:0] r_div_cnt;
    logic             r_div_busy;
    logic             r_div_done;

    logic [63:0]      w_shift;
    logic [31:0]      w_dsize;
    logic [31:0]      w_id;
    logic [4:0]       w_idx_full;
    logic [3:0]       w_idx;
    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;
    logic [DEN_W-1:0] n_div_rem;
    logic [31:0]      n_div_quo;

    function automatic logic [31:0] swap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    // A first mark clears the parse before its byte is worked on
    always_comb begin
        e_pos      = i_cmd.clr ? '0 : r_pos;
        e_cd       = i_cmd.clr ? '0 : r_cd;
        e_shift    = i_cmd.clr ? '0 : r_shift;
        e_fmt_seen = i_cmd.clr ? 1'b0 : r_fmt_seen;
        e_fmt_code = i_cmd.clr ? '0 : r_fmt_code;
        e_chan     = i_cmd.clr ? '0 : r_chan;
        e_rate     = i_cmd.clr ? '0 : r_rate;
        e_bits     = i_cmd.clr ? '0 : r_bits;
    end

    assign w_shift    = {e_shift[55:0], i_file_byte};
    assign w_dsize    = swap32(w_shift[31:0]);
    assign w_id       = w_shift[63:32];
    assign w_idx_full = 5'd16 - e_cd[4:0];
    assign w_idx      = w_idx_full[3:0];

    always_comb begin
        o_status            = '0;
        o_status.pos3       = (e_pos == 32'd3);
        o_status.pos11      = (e_pos == 32'd11);
        o_status.riff_bad   = (w_shift[31:0] != TAG_RIFF);
        o_status.wave_ok    = (w_shift[31:0] == TAG_WAVE);
        o_status.flag       = (e_cd != '0);
        o_status.cd_last    = (e_cd == 32'd1);
        o_status.is_fmt     = (w_id == TAG_FMT);
        o_status.is_data    = (w_id == TAG_DATA);
        o_status.fmt_small  = (w_dsize < FMT_LEN);
        o_status.size_zero  = (w_dsize == '0);
        o_status.extra_zero = (e_shift[31:0] == '0);
        o_status.fmt_seen   = e_fmt_seen;
        o_status.pcm        = (e_fmt_code == FMT_PCM);
        o_status.bpb_zero   = (e_bits[15:3] == '0);
        o_status.div_done   = r_div_done;
    end

    always_comb begin
        n_pos      = e_pos;
        n_cd       = e_cd;
        n_shift    = e_shift;
        n_fmt_seen = e_fmt_seen | i_cmd.set_fmt;
        n_fmt_code = e_fmt_code;
        n_chan     = e_chan;
        n_rate     = e_rate;
        n_bits     = e_bits;
        if (i_cmd.op != OP_NONE) begin
            n_pos = e_pos + 32'd1;
        end
        if (i_cmd.op == OP_RIFF || i_cmd.op == OP_CHDR) begin
            n_shift = w_shift;
        end
        // hold the count of fmt bytes beyond the first sixteen
        if (i_cmd.load_extra) begin
            n_shift = {32'd0, w_dsize - FMT_LEN};
        end
        if (i_cmd.op == OP_FMT) begin
            case (w_idx)
                4'd0:    n_fmt_code[7:0]  = i_file_byte;
                4'd1:    n_fmt_code[15:8] = i_file_byte;
                4'd2:    n_chan[7:0]      = i_file_byte;
                4'd3:    n_chan[15:8]     = i_file_byte;
                4'd4:    n_rate[7:0]      = i_file_byte;
                4'd5:    n_rate[15:8]     = i_file_byte;
                4'd6:    n_rate[23:16]    = i_file_byte;
                4'd7:    n_rate[31:24]    = i_file_byte;
                4'd14:   n_bits[7:0]      = i_file_byte;
                4'd15:   n_bits[15:8]     = i_file_byte;
                default: ;
            endcase
        end
        case (i_cmd.cd_sel)
            CD_KEEP:  n_cd = e_cd;
            CD_DEC:   n_cd = e_cd - 32'd1;
            CD_FLAG:  n_cd = 32'd1;
            CD_HDR:   n_cd = CHUNK_HDR_LEN;
            CD_FMT:   n_cd = FMT_LEN;
            CD_SIZE:  n_cd = w_dsize;
            CD_EXTRA: n_cd = e_shift[31:0];
            default:  n_cd = e_cd;
        endcase
    end

    // one quotient bit per cycle
    assign w_trial   = {r_div_rem, r_div_quo[31]};
    assign w_ge      = (w_trial >= {1'b0, r_div_den});
    assign w_diff    = w_trial - {1'b0, r_div_den};
    assign n_div_rem = w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
    assign n_div_quo = {r_div_quo[30:0], w_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_cd       <= '0;
            r_fmt_seen <= 1'b0;
            r_div_cnt  <= '0;
            r_div_busy <= 1'b0;
            r_div_done <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_cd       <= n_cd;
            r_fmt_seen <= n_fmt_seen;
            r_div_done <= 1'b0;
            if (i_cmd.div_start) begin
                r_div_cnt  <= '0;
                r_div_busy <= 1'b1;
            end else if (r_div_busy) begin
                r_div_cnt <= r_div_cnt + 1'b1;
                if (r_div_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    r_div_busy <= 1'b0;
                    r_div_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift    <= n_shift;
        r_fmt_code <= n_fmt_code;
        r_chan     <= n_chan;
        r_rate     <= n_rate;
        r_bits     <= n_bits;
        if (i_cmd.res_load) begin
            r_res              <= '0;
            r_res.status       <= i_cmd.res_status;
            if (i_cmd.res_status == ST_OK) begin
                r_res.channel_count <= e_chan;
                r_res.sample_rate   <= e_rate;
                r_res.sample_bits   <= e_bits;
                r_res.data_bytes    <= w_dsize;
                r_res.data_start    <= e_pos + 32'd1;
            end
        end
        if (i_cmd.div_start) begin
            r_div_quo <= w_dsize;
            r_div_rem <= '0;
            r_div_den <= e_bits[15:3];
        end else if (r_div_busy) begin
            r_div_quo <= n_div_quo;
            r_div_rem <= n_div_rem;
            if (r_div_cnt == CNT_W'(DIV_STEPS - 1)) begin
                r_res.sample_total <= n_div_quo;
            end
        end
    end

    assign o_result = r_res;

    `WRP_ASSERT(a_div_starts, i_cmd.div_start |=> (r_div_busy && r_div_cnt == '0), "divider did not start")
    `WRP_ASSERT(a_done_after_busy, r_div_done |-> $past(r_div_busy), "divide done without a run")
    `WRP_ASSERT_NEVER(a_zero_divisor, r_div_busy && (r_div_den == '0), "divider running on a zero divisor")

endmodule
